// ----- hdl/phrm_pkg.sv -----
// Shared types and constants for the peak/hold/RMS level meter.
`default_nettype none
package phrm_pkg;

    // Configuration register widths and indexes
    localparam int HOLD_W  = 20;
    localparam int DECAY_W = 24;
    localparam int WIN_W   = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_WINDOW   = 2'd2;

    localparam logic [HOLD_W-1:0]  HOLD_LENGTH_RST  = 20'd48000;
    localparam logic [DECAY_W-1:0] DECAY_FACTOR_RST = 24'd16776411;
    localparam logic [WIN_W-1:0]   RMS_WINDOW_RST   = 20'd19200;

    // Level and accumulator widths
    localparam int LEVEL_W = 16;
    localparam int SUM_W   = 51;
    localparam int COUNT_W = 21;
    localparam int Q24_W   = 25;
    localparam logic [Q24_W-1:0] ONE_Q24 = 25'h100_0000;

    // Square root / divider step counter
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd51;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd26;

    // Control part of one queued request
    typedef struct packed {
        logic valid;
        logic clear;
        logic last;
    } phrm_item_ctl_t;

    // Back end sequencer
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HELD = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_RMS  = 5'b01000,
        ST_EMIT = 5'b10000
    } phrm_state_t;

    // Divide / square root unit
    typedef enum logic [2:0] {
        RS_IDLE = 3'b001,
        RS_DIV  = 3'b010,
        RS_SQRT = 3'b100
    } phrm_rs_state_t;

endpackage
`default_nettype wire

// ----- hdl/phrm_front.sv -----
// Front end: two-entry request queue that classifies requests and squares magnitudes.
`default_nettype none
module phrm_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       action,
    input  wire logic [SAMPLE_BITS-1:0]     sample,
    input  wire logic                       last_in_block,
    output phrm_pkg::phrm_item_ctl_t        item_ctl,
    output logic [SAMPLE_BITS-1:0]          item_mag,
    output logic [2*SAMPLE_BITS-2:0]        item_sq,
    input  wire logic                       item_pop
);
    import phrm_pkg::*;

    localparam int MAG_W = SAMPLE_BITS;
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;

    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       clear_q, last_q;
    logic [MAG_W-1:0] mag_q [2];
    logic [SQ_W-1:0]  sq_q [2];

    logic                 do_push, do_pop;
    logic [MAG_W-1:0]     mag;
    logic [2*MAG_W-1:0]   sq_full;

    // Magnitude of the two's complement sample; the most negative code maps to 2^(N-1)
    always_comb
    begin
        if (sample[MAG_W-1])
            mag = MAG_W'(~sample) + MAG_W'(1);
        else
            mag = sample;
        sq_full = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
    end

    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign do_pop   = item_pop && (count_reg != 2'd0);

    assign item_ctl.valid = (count_reg != 2'd0);
    assign item_ctl.clear = clear_q[rd_ptr_reg];
    assign item_ctl.last  = last_q[rd_ptr_reg];
    assign item_mag       = mag_q[rd_ptr_reg];
    assign item_sq        = sq_q[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            clear_q[wr_ptr_reg] <= action;
            last_q[wr_ptr_reg]  <= last_in_block;
            mag_q[wr_ptr_reg]   <= mag;
            sq_q[wr_ptr_reg]    <= sq_full[SQ_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/phrm_rms.sv -----
// Iterative unit: bit-serial divide of the square sum by the count, then integer square root.
`default_nettype none
module phrm_rms (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [phrm_pkg::SUM_W-1:0]     sum,
    input  wire logic [phrm_pkg::COUNT_W-1:0]   count,
    output logic                                done,
    output logic [phrm_pkg::LEVEL_W-1:0]        root
);
    import phrm_pkg::*;

    phrm_rs_state_t    state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  num_reg, num_next;
    logic [COUNT_W:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0] den_reg, den_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [SUM_W-1:0]  res_reg, res_next;
    logic [SUM_W-1:0]  bit_reg, bit_next;
    logic              zero_reg, zero_next;
    logic              done_reg, done_next;

    logic [COUNT_W:0]  trial;
    logic [SUM_W-1:0]  cand;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[COUNT_W-1:0], num_reg[SUM_W-1]};
        cand       = res_reg + bit_reg;
        case (state_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    num_next   = sum;
                    den_next   = count;
                    rem_next   = '0;
                    quo_next   = '0;
                    zero_next  = (count == '0);
                    step_next  = DIV_STEPS;
                    state_next = RS_DIV;
                end
            end
            RS_DIV:
            begin
                // One quotient bit per cycle, restoring
                num_next = {num_reg[SUM_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    res_next   = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 1);
                    step_next  = SQRT_STEPS;
                    state_next = RS_SQRT;
                end
            end
            RS_SQRT:
            begin
                // One root bit per cycle
                if (quo_reg >= cand)
                begin
                    quo_next = quo_reg - cand;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = RS_IDLE;
                end
            end
            default:
            begin
                state_next = RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign root = zero_reg ? '0 : res_reg[LEVEL_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/phrm_back.sv -----
// Back end: per-sample accumulation, block end rules and the result register.
`default_nettype none
module phrm_back #(
    parameter int MAX_BLOCK   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire phrm_pkg::phrm_item_ctl_t       item_ctl,
    input  wire logic [SAMPLE_BITS-1:0]         item_mag,
    input  wire logic [2*SAMPLE_BITS-2:0]       item_sq,
    output logic                                item_pop,
    input  wire logic [phrm_pkg::HOLD_W-1:0]    hold_length,
    input  wire logic [phrm_pkg::DECAY_W-1:0]   decay_factor,
    input  wire logic [phrm_pkg::WIN_W-1:0]     rms_window,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [phrm_pkg::LEVEL_W-1:0]        peak_level,
    output logic [phrm_pkg::LEVEL_W-1:0]        held_level,
    output logic [phrm_pkg::LEVEL_W-1:0]        rms_level,
    output logic                                rms_fresh
);
    import phrm_pkg::*;

    localparam int MAG_W = SAMPLE_BITS;
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int LEN_W = $clog2(MAX_BLOCK + 1);
    localparam logic [LEN_W-1:0] LEN_END = LEN_W'(MAX_BLOCK);

    phrm_state_t        state_reg, state_next;
    logic [MAG_W-1:0]   block_max_reg, block_max_next;
    logic [Q24_W-1:0]   block_decay_reg, block_decay_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [MAG_W-1:0]   running_reg, running_next;
    logic [MAG_W-1:0]   held_reg, held_next;
    logic [HOLD_W-1:0]  hold_rem_reg, hold_rem_next;
    logic [LEVEL_W-1:0] rms_reg, rms_next;
    logic               fresh_reg, fresh_next;

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_peak_reg, out_peak_next;
    logic [LEVEL_W-1:0] out_held_reg, out_held_next;
    logic [LEVEL_W-1:0] out_rms_reg, out_rms_next;
    logic               out_fresh_reg, out_fresh_next;

    logic                         rms_start, rms_done;
    logic [LEVEL_W-1:0]           rms_root;
    logic [Q24_W+DECAY_W-1:0]     bdecay_prod;
    logic [MAG_W+DECAY_W-1:0]     held_prod;
    logic [MAG_W+Q24_W-1:0]       run_prod;
    logic [SUM_W:0]               sum_add;
    logic [LEN_W-1:0]             len_inc;
    logic [HOLD_W-1:0]            len_ext;
    logic                         out_free;

    phrm_rms u_rms (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rms_start),
        .sum   (sum_reg),
        .count (count_reg),
        .done  (rms_done),
        .root  (rms_root)
    );

    always_comb
    begin
        bdecay_prod = (Q24_W+DECAY_W)'(block_decay_reg) * (Q24_W+DECAY_W)'(decay_factor);
        held_prod   = (MAG_W+DECAY_W)'(held_reg) * (MAG_W+DECAY_W)'(decay_factor);
        run_prod    = (MAG_W+Q24_W)'(running_reg) * (MAG_W+Q24_W)'(block_decay_reg);
        sum_add     = {1'b0, sum_reg} + (SUM_W+1)'(item_sq);
        len_inc     = len_reg + LEN_W'(1);
        len_ext     = HOLD_W'(len_reg);
        out_free    = !out_valid_reg || pop;
    end

    always_comb
    begin
        state_next       = state_reg;
        block_max_next   = block_max_reg;
        block_decay_next = block_decay_reg;
        len_next         = len_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        running_next     = running_reg;
        held_next        = held_reg;
        hold_rem_next    = hold_rem_reg;
        rms_next         = rms_reg;
        fresh_next       = fresh_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_peak_next    = out_peak_reg;
        out_held_next    = out_held_reg;
        out_rms_next     = out_rms_reg;
        out_fresh_next   = out_fresh_reg;
        item_pop         = 1'b0;
        rms_start        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_ctl.valid)
                begin
                    item_pop = 1'b1;
                    if (item_ctl.clear)
                    begin
                        // Drop all meter state
                        block_max_next   = '0;
                        block_decay_next = ONE_Q24;
                        len_next         = '0;
                        sum_next         = '0;
                        count_next       = '0;
                        running_next     = '0;
                        held_next        = '0;
                        hold_rem_next    = '0;
                        rms_next         = '0;
                        fresh_next       = 1'b0;
                    end
                    else
                    begin
                        // Accumulate one sample
                        if (item_mag > block_max_reg)
                            block_max_next = item_mag;
                        block_decay_next = bdecay_prod[Q24_W+DECAY_W-1:DECAY_W];
                        sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                        if (count_reg != '1)
                            count_next = count_reg + COUNT_W'(1);
                        len_next = len_inc;
                        if (item_ctl.last || len_inc == LEN_END)
                            state_next = ST_HELD;
                    end
                end
            end
            ST_HELD:
            begin
                // Held peak: capture, count the hold down, or decay
                if (block_max_reg >= held_reg)
                begin
                    held_next     = block_max_reg;
                    hold_rem_next = hold_length;
                end
                else if (hold_rem_reg != '0)
                begin
                    hold_rem_next = (hold_rem_reg > len_ext) ? hold_rem_reg - len_ext : '0;
                end
                else
                begin
                    held_next = held_prod[MAG_W+DECAY_W-1:DECAY_W];
                end
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // Running peak: capture or decay over the block
                if (block_max_reg > running_reg)
                    running_next = block_max_reg;
                else
                    running_next = run_prod[MAG_W+DECAY_W-1:DECAY_W];
                if (count_reg >= COUNT_W'(rms_window))
                begin
                    rms_start  = 1'b1;
                    state_next = ST_RMS;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RMS:
            begin
                if (rms_done)
                begin
                    rms_next   = rms_root;
                    sum_next   = '0;
                    count_next = '0;
                    fresh_next = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hand the result to the output register and restart the block
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_peak_next    = LEVEL_W'(running_reg);
                    out_held_next    = LEVEL_W'(held_reg);
                    out_rms_next     = rms_reg;
                    out_fresh_next   = fresh_reg;
                    block_max_next   = '0;
                    block_decay_next = ONE_Q24;
                    len_next         = '0;
                    fresh_next       = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_max_reg   <= '0;
            block_decay_reg <= ONE_Q24;
            len_reg         <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            running_reg     <= '0;
            held_reg        <= '0;
            hold_rem_reg    <= '0;
            rms_reg         <= '0;
            fresh_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            block_max_reg   <= block_max_next;
            block_decay_reg <= block_decay_next;
            len_reg         <= len_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            running_reg     <= running_next;
            held_reg        <= held_next;
            hold_rem_reg    <= hold_rem_next;
            rms_reg         <= rms_next;
            fresh_reg       <= fresh_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_peak_reg  <= out_peak_next;
        out_held_reg  <= out_held_next;
        out_rms_reg   <= out_rms_next;
        out_fresh_reg <= out_fresh_next;
    end

    assign empty      = !out_valid_reg;
    assign peak_level = out_peak_reg;
    assign held_level = out_held_reg;
    assign rms_level  = out_rms_reg;
    assign rms_fresh  = out_fresh_reg;

endmodule
`default_nettype wire

// ----- hdl/peak_hold_rms_level_meter.sv -----
// Top level of the peak / peak-hold / RMS level meter.
// Requests enter a two-entry queue and are handled one at a time by the back end.
// A sample that does not end a block, and a clear, are taken in the idle state.
// A block end passes through the held, running-peak and emit states, and the RMS
// state as well when the RMS window is full: the RMS is formed by one shared
// iterative unit that divides the square sum by the count one quotient bit a
// cycle and then takes the square root one bit a cycle. One result is held in an
// output register, so the back end goes on while a result waits to be popped.
// Configuration writes are always taken and must be made while the meter is idle.
`default_nettype none
module peak_hold_rms_level_meter #(
    parameter int MAX_BLOCK   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               action,
    input  wire logic [SAMPLE_BITS-1:0]             sample,
    input  wire logic                               last_in_block,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [phrm_pkg::LEVEL_W-1:0]            peak_level,
    output logic [phrm_pkg::LEVEL_W-1:0]            held_level,
    output logic [phrm_pkg::LEVEL_W-1:0]            rms_level,
    output logic                                    rms_fresh,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [phrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [phrm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import phrm_pkg::*;

    logic [HOLD_W-1:0]  hold_length_reg;
    logic [DECAY_W-1:0] decay_factor_reg;
    logic [WIN_W-1:0]   rms_window_reg;

    phrm_item_ctl_t          item_ctl;
    logic [SAMPLE_BITS-1:0]  item_mag;
    logic [2*SAMPLE_BITS-2:0] item_sq;
    logic                    item_pop;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_length_reg  <= HOLD_LENGTH_RST;
            decay_factor_reg <= DECAY_FACTOR_RST;
            rms_window_reg   <= RMS_WINDOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HOLD_LENGTH:  hold_length_reg  <= cfg_data[HOLD_W-1:0];
                CFG_DECAY_FACTOR: decay_factor_reg <= cfg_data[DECAY_W-1:0];
                CFG_RMS_WINDOW:   rms_window_reg   <= cfg_data[WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    phrm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .sample        (sample),
        .last_in_block (last_in_block),
        .item_ctl      (item_ctl),
        .item_mag      (item_mag),
        .item_sq       (item_sq),
        .item_pop      (item_pop)
    );

    phrm_back #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ctl     (item_ctl),
        .item_mag     (item_mag),
        .item_sq      (item_sq),
        .item_pop     (item_pop),
        .hold_length  (hold_length_reg),
        .decay_factor (decay_factor_reg),
        .rms_window   (rms_window_reg),
        .empty        (empty),
        .pop          (pop),
        .peak_level   (peak_level),
        .held_level   (held_level),
        .rms_level    (rms_level),
        .rms_fresh    (rms_fresh)
    );

endmodule
`default_nettype wire

// ----- hdl/phrm_checker.sv -----
// Port-level checks for the level meter, bound to the top level.
`default_nettype none
module phrm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [15:0] peak_level,
    input  wire logic [15:0] held_level,
    input  wire logic [15:0] rms_level,
    input  wire logic        rms_fresh
);
    localparam logic [15:0] LEVEL_MAX = (SAMPLE_BITS <= 16) ? 16'h8000 : 16'hFFFF;

    // Hold a waiting result until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped before pop");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(peak_level) && $stable(held_level)
                           && $stable(rms_level) && $stable(rms_fresh))
        else $error("result changed while waiting");

    // Levels never exceed full-scale magnitude
    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> peak_level <= LEVEL_MAX && held_level <= LEVEL_MAX
                   && rms_level <= LEVEL_MAX)
        else $error("level above full scale");

endmodule

bind peak_hold_rms_level_meter phrm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_phrm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .peak_level (peak_level),
    .held_level (held_level),
    .rms_level  (rms_level),
    .rms_fresh  (rms_fresh)
);
`default_nettype wire
